[design/atis_pkg.sv]
// atis_pkg: shared types and constants of the alarm timer with interrupt suspend
// used by every module of the block; depends on nothing
`default_nettype none

package atis_pkg;

    localparam int SUSPEND_DEPTH_BITS = 8;
    localparam int TICK_BITS          = 64;
    localparam int WORD_BITS          = 32;
    localparam int S_TDATA_BITS       = 48;
    localparam int M_TDATA_BITS       = 40;
    localparam logic [2:0] ACCESS_BYTES = 3'd4;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_READ    = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_SUSPEND = 3'd3,
        ACT_RESUME  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        WORD_LO    = 2'd0,
        WORD_HI    = 2'd1,
        WORD_ALARM = 2'd2,
        WORD_NONE  = 2'd3
    } word_sel_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [WORD_BITS-1:0] write_data;
        logic [2:0]           access_size;
        logic [3:0]           reg_offset;
        logic [2:0]           action;
    } in_word_t;

    typedef struct packed {
        logic                 irq_level;
        logic                 access_ok;
        logic [WORD_BITS-1:0] read_data;
    } result_t;

    localparam int IN_WORD_BITS = $bits(in_word_t);
    localparam int RESULT_BITS  = $bits(result_t);

endpackage

`default_nettype wire

[design/atis_in_reg.sv]
// atis_in_reg: input register stage of the alarm timer
// depends on atis_pkg
`default_nettype none

module atis_in_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire atis_pkg::in_word_t   in_word,
    output logic                      held_valid,
    input  wire logic                 held_take,
    output atis_pkg::in_word_t        held_word
);

    logic               valid_reg;
    logic               valid_next;
    atis_pkg::in_word_t word_reg;

    assign in_ready   = !valid_reg || held_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

`default_nettype wire

[design/atis_exec.sv]
// atis_exec: timer state (tick counter, alarm, pending flag, suspend depth, irq line)
// and the single-pass update for one word; depends on atis_pkg
`default_nettype none

module atis_exec (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire atis_pkg::in_word_t   item,
    output atis_pkg::result_t         result
);

    localparam logic [atis_pkg::SUSPEND_DEPTH_BITS-1:0] DEPTH_MAX = '1;

    logic [atis_pkg::TICK_BITS-1:0]          tick_count_reg, tick_count_next;
    logic [atis_pkg::WORD_BITS-1:0]          alarm_reg, alarm_next;
    logic                                    pending_reg, pending_next;
    logic [atis_pkg::SUSPEND_DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                                    irq_reg, irq_next;

    logic                                    size_ok;
    logic                                    do_update;
    logic [atis_pkg::WORD_BITS-1:0]          rdata;
    logic                                    ok;
    atis_pkg::word_sel_t                     word;

    assign size_ok = (item.access_size == atis_pkg::ACCESS_BYTES);
    assign word    = atis_pkg::word_sel_t'(item.reg_offset[3:2]);

    always_comb begin
        tick_count_next = tick_count_reg;
        alarm_next      = alarm_reg;
        pending_next    = pending_reg;
        depth_next      = depth_reg;
        do_update       = 1'b0;
        rdata           = '0;
        ok              = 1'b1;
        case (atis_pkg::action_t'(item.action))
            atis_pkg::ACT_TICK: begin
                tick_count_next = tick_count_reg + 1'b1;
                if (alarm_reg != '0) begin
                    alarm_next = alarm_reg - 1'b1;
                    if (alarm_reg == {{(atis_pkg::WORD_BITS-1){1'b0}}, 1'b1}) begin
                        pending_next = 1'b1;
                        do_update    = 1'b1;
                    end
                end
            end
            atis_pkg::ACT_READ: begin
                if (!size_ok) begin
                    ok = 1'b0;
                end else begin
                    case (word)
                        atis_pkg::WORD_LO:    rdata = tick_count_reg[atis_pkg::WORD_BITS-1:0];
                        atis_pkg::WORD_HI:    rdata = tick_count_reg[atis_pkg::TICK_BITS-1:
                                                                     atis_pkg::WORD_BITS];
                        atis_pkg::WORD_ALARM: rdata = alarm_reg;
                        default:              ok = 1'b0;
                    endcase
                end
            end
            atis_pkg::ACT_WRITE: begin
                if (!size_ok) begin
                    ok = 1'b0;
                end else begin
                    case (word)
                        atis_pkg::WORD_LO: begin
                            pending_next = 1'b0;
                            do_update    = 1'b1;
                        end
                        atis_pkg::WORD_ALARM: alarm_next = item.write_data;
                        default:              ok = 1'b0;
                    endcase
                end
            end
            atis_pkg::ACT_SUSPEND: begin
                if (depth_reg != DEPTH_MAX) begin
                    depth_next = depth_reg + 1'b1;
                end
                do_update = 1'b1;
            end
            atis_pkg::ACT_RESUME: begin
                if (depth_reg != '0) begin
                    depth_next = depth_reg - 1'b1;
                end
                do_update = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // held while suspended with the flag pending, and on words that do not update it
    always_comb begin
        irq_next = irq_reg;
        if (do_update && !(depth_next != '0 && pending_next)) begin
            irq_next = pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            alarm_reg      <= '0;
            pending_reg    <= 1'b0;
            depth_reg      <= '0;
            irq_reg        <= 1'b0;
        end else if (fire) begin
            tick_count_reg <= tick_count_next;
            alarm_reg      <= alarm_next;
            pending_reg    <= pending_next;
            depth_reg      <= depth_next;
            irq_reg        <= irq_next;
        end
    end

    assign result.read_data = rdata;
    assign result.access_ok = ok;
    assign result.irq_level = irq_next;

    a_irq_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_reg |-> pending_reg)
        else $error("irq line high without pending flag");

    a_irq_when_unsuspended: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_reg == '0 && pending_reg) |-> irq_reg)
        else $error("pending flag not raised while unsuspended");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(tick_count_reg) && $stable(alarm_reg) && $stable(depth_reg))
        else $error("timer state changed without a word");

    a_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.action == atis_pkg::ACT_TICK)
        |=> tick_count_reg == $past(tick_count_reg) + 1'b1)
        else $error("tick did not advance the counter");

endmodule

`default_nettype wire

[design/atis_out_reg.sv]
// atis_out_reg: result register stage of the alarm timer
// depends on atis_pkg
`default_nettype none

module atis_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load_valid,
    output logic                     load_ready,
    input  wire atis_pkg::result_t   load_result,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output atis_pkg::result_t        out_result
);

    logic              valid_reg;
    logic              valid_next;
    atis_pkg::result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

[design/alarm_timer_with_irq_suspend_core.sv]
// alarm_timer_with_irq_suspend_core: top level of the alarm timer with interrupt suspend
// depends on atis_pkg, atis_in_reg, atis_exec, atis_out_reg
//
//   channel   ports      width  contents (lowest bit first)
//   input     s_axis_*   48     action[2:0] reg_offset[6:3] access_size[9:7] write_data[41:10]
//   result    m_axis_*   40     read_data[31:0] access_ok[32] irq_level[33]
//
// one word per cycle sustained while m_axis is not stalled; a word's result reaches m_axis
// through the input register, then the state update into the result register
// aresetn clears counter, alarm, pending flag, suspend depth and irq line
// a stalled m_axis holds the result register, the input register fills, then s_axis_tready drops
`default_nettype none

module alarm_timer_with_irq_suspend_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // action, reg_offset, access_size, write_data
    input  wire logic [atis_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // read_data, access_ok, irq_level
    output logic [atis_pkg::M_TDATA_BITS-1:0]       m_axis_tdata
);

    atis_pkg::in_word_t in_word;
    atis_pkg::in_word_t held_word;
    atis_pkg::result_t  exec_result;
    atis_pkg::result_t  out_result;
    logic               held_valid;
    logic               load_ready;
    logic               fire;

    assign in_word = atis_pkg::in_word_t'(s_axis_tdata[atis_pkg::IN_WORD_BITS-1:0]);
    assign fire    = held_valid && load_ready;

    atis_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .held_valid (held_valid),
        .held_take  (load_ready),
        .held_word  (held_word)
    );

    atis_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (held_word),
        .result  (exec_result)
    );

    atis_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (held_valid),
        .load_ready  (load_ready),
        .load_result (exec_result),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = {{(atis_pkg::M_TDATA_BITS-atis_pkg::RESULT_BITS){1'b0}}, out_result};

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for alarm_timer_with_irq_suspend_core
// depends on atis_pkg and the core; a scoreboard class predicts every result word
// the bench uses directed words, a suspend saturation walk, then random bursts with receiver stalls

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 100;

    class timer_scoreboard;
        logic [atis_pkg::TICK_BITS-1:0]          tick_count;
        logic [atis_pkg::WORD_BITS-1:0]          alarm_left;
        logic                                    alarm_flag;
        logic [atis_pkg::SUSPEND_DEPTH_BITS-1:0] depth;
        logic                                    irq;
        atis_pkg::result_t                       due_results[$];
        int                                      errors;

        function new();
            tick_count = '0;
            alarm_left = '0;
            alarm_flag = 1'b0;
            depth      = '0;
            irq        = 1'b0;
            errors     = 0;
        endfunction

        function void refresh_irq();
            if (depth != 0 && alarm_flag) begin
                return;
            end
            irq = alarm_flag;
        endfunction

        // advances the timer by one input word and queues the word it must answer
        function void note_word(atis_pkg::in_word_t w);
            atis_pkg::result_t   r;
            atis_pkg::word_sel_t sel;
            logic                wr;
            r   = '0;
            r.access_ok = 1'b1;
            sel = atis_pkg::word_sel_t'(w.reg_offset[3:2]);
            wr  = (w.action == atis_pkg::ACT_WRITE);
            case (w.action)
                atis_pkg::ACT_TICK: begin
                    tick_count = tick_count + 1;
                    if (alarm_left != 0) begin
                        alarm_left = alarm_left - 1;
                        if (alarm_left == 0) begin
                            alarm_flag = 1'b1;
                            refresh_irq();
                        end
                    end
                end
                atis_pkg::ACT_READ, atis_pkg::ACT_WRITE: begin
                    if (w.access_size != atis_pkg::ACCESS_BYTES) begin
                        r.access_ok = 1'b0;
                    end else begin
                        case (sel)
                            atis_pkg::WORD_LO: begin
                                if (wr) begin
                                    alarm_flag = 1'b0;
                                    refresh_irq();
                                end else begin
                                    r.read_data = tick_count[atis_pkg::WORD_BITS-1:0];
                                end
                            end
                            atis_pkg::WORD_HI: begin
                                if (wr) begin
                                    r.access_ok = 1'b0;
                                end else begin
                                    r.read_data = tick_count[atis_pkg::TICK_BITS-1:
                                                             atis_pkg::WORD_BITS];
                                end
                            end
                            atis_pkg::WORD_ALARM: begin
                                if (wr) begin
                                    alarm_left = w.write_data;
                                end else begin
                                    r.read_data = alarm_left;
                                end
                            end
                            default: begin
                                r.access_ok = 1'b0;
                            end
                        endcase
                    end
                end
                atis_pkg::ACT_SUSPEND: begin
                    if (depth != {atis_pkg::SUSPEND_DEPTH_BITS{1'b1}}) begin
                        depth = depth + 1'b1;
                    end
                    refresh_irq();
                end
                atis_pkg::ACT_RESUME: begin
                    if (depth != 0) begin
                        depth = depth - 1'b1;
                    end
                    refresh_irq();
                end
                default: begin
                end
            endcase
            r.irq_level = irq;
            due_results.push_back(r);
        endfunction

        function void check_result(logic [atis_pkg::M_TDATA_BITS-1:0] data);
            atis_pkg::result_t got;
            atis_pkg::result_t want;
            got = atis_pkg::result_t'(data[atis_pkg::RESULT_BITS-1:0]);
            if (due_results.size() == 0) begin
                if (errors < 10) begin
                    $display("unexpected result word %h", data);
                end
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.read_data !== want.read_data || got.access_ok !== want.access_ok
                    || got.irq_level !== want.irq_level) begin
                if (errors < 10) begin
                    $display({"mismatch: read_data exp %h got %h, access_ok exp %b got %b,",
                              " irq exp %b got %b"},
                             want.read_data, got.read_data, want.access_ok, got.access_ok,
                             want.irq_level, got.irq_level);
                end
                errors++;
            end
        endfunction
    endclass

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [atis_pkg::S_TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [atis_pkg::M_TDATA_BITS-1:0] m_axis_tdata;

    timer_scoreboard sb = new();

    logic [7:0] stall_pattern = 8'hff;
    int         stall_cycle   = 0;

    always #6 aclk = ~aclk;

    alarm_timer_with_irq_suspend_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // watch both channels and drive the receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_word(atis_pkg::in_word_t'(s_axis_tdata[atis_pkg::IN_WORD_BITS-1:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
        end
        if (stall_cycle == 63) begin
            stall_cycle   <= 0;
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
        end else begin
            stall_cycle   <= stall_cycle + 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
        m_axis_tready <= stall_pattern[0];
    end

    function automatic atis_pkg::in_word_t make_word(logic [2:0] act, logic [3:0] offset,
                                                     logic [2:0] size, logic [31:0] data);
        atis_pkg::in_word_t w;
        w.action      = act;
        w.reg_offset  = offset;
        w.access_size = size;
        w.write_data  = data;
        return w;
    endfunction

    function automatic atis_pkg::in_word_t random_word();
        atis_pkg::in_word_t w;
        int                 pick;
        w    = atis_pkg::in_word_t'(atis_pkg::IN_WORD_BITS'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0) begin
            w.access_size = atis_pkg::ACCESS_BYTES;
        end
        if ($urandom_range(0, 4) != 0) begin
            w.reg_offset[3:2] = 2'($urandom_range(0, 2));
        end
        if (pick < 40) begin
            w.action = atis_pkg::ACT_TICK;
        end else if (pick < 52) begin
            w.action = atis_pkg::ACT_READ;
        end else if (pick < 67) begin
            w.action = atis_pkg::ACT_WRITE;
            if ($urandom_range(0, 1) == 0) begin
                w.reg_offset[3:2] = atis_pkg::WORD_ALARM;
            end
            if ($urandom_range(0, 4) != 0) begin
                w.write_data = $urandom_range(1, 12);
            end
        end else if (pick < 77) begin
            w.action = atis_pkg::ACT_SUSPEND;
        end else if (pick < 87) begin
            w.action = atis_pkg::ACT_RESUME;
        end else if (pick < 93) begin
            w.action          = atis_pkg::ACT_WRITE;
            w.reg_offset[3:2] = atis_pkg::WORD_LO;
            w.access_size     = atis_pkg::ACCESS_BYTES;
        end else begin
            w.action = 3'($urandom_range(5, 7));
        end
        return w;
    endfunction

    task automatic send_word(input atis_pkg::in_word_t w);
        s_axis_tdata  <= atis_pkg::S_TDATA_BITS'(w);
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    initial begin
        atis_pkg::in_word_t directed[$];
        int                 burst;
        int                 sent;
        directed = '{
            make_word(atis_pkg::ACT_READ,    4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_READ,    4'd4,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_READ,    4'd8,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_READ,    4'd12, 3'd4, 32'h0),
            make_word(atis_pkg::ACT_TICK,    4'd0,  3'd0, 32'h0),
            make_word(atis_pkg::ACT_READ,    4'd3,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_WRITE,   4'd8,  3'd4, 32'd2),
            make_word(atis_pkg::ACT_READ,    4'd9,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_TICK,    4'd15, 3'd7, 32'hffffffff),
            make_word(atis_pkg::ACT_TICK,    4'd0,  3'd0, 32'h0),
            make_word(atis_pkg::ACT_WRITE,   4'd0,  3'd4, 32'hffffffff),
            make_word(atis_pkg::ACT_WRITE,   4'd4,  3'd4, 32'h12345678),
            make_word(atis_pkg::ACT_WRITE,   4'd13, 3'd4, 32'h5),
            make_word(atis_pkg::ACT_READ,    4'd8,  3'd2, 32'h0),
            make_word(atis_pkg::ACT_WRITE,   4'd8,  3'd1, 32'h7),
            make_word(atis_pkg::ACT_WRITE,   4'd11, 3'd4, 32'd1),
            make_word(atis_pkg::ACT_SUSPEND, 4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_TICK,    4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_RESUME,  4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_RESUME,  4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_SUSPEND, 4'd0,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_WRITE,   4'd1,  3'd4, 32'h0),
            make_word(atis_pkg::ACT_RESUME,  4'd0,  3'd4, 32'h0),
            make_word(3'd5,                  4'd8,  3'd4, 32'h1),
            make_word(3'd6,                  4'd0,  3'd4, 32'h1),
            make_word(3'd7,                  4'd4,  3'd3, 32'h1),
            make_word(atis_pkg::ACT_WRITE,   4'd8,  3'd4, 32'hffffffff),
            make_word(atis_pkg::ACT_READ,    4'd10, 3'd4, 32'h0),
            make_word(atis_pkg::ACT_WRITE,   4'd8,  3'd4, 32'h0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_word(directed[i]);
        end

        // walk the suspend depth into saturation with an alarm expiring on top
        send_word(make_word(atis_pkg::ACT_WRITE, 4'd8, 3'd4, 32'd1));
        repeat (260) send_word(make_word(atis_pkg::ACT_SUSPEND, 4'($urandom), 3'($urandom),
                                         $urandom));
        send_word(make_word(atis_pkg::ACT_TICK, 4'd0, 3'd4, 32'h0));
        send_word(make_word(atis_pkg::ACT_SUSPEND, 4'd0, 3'd4, 32'h0));
        repeat (258) send_word(make_word(atis_pkg::ACT_RESUME, 4'($urandom), 3'($urandom),
                                         $urandom));
        send_word(make_word(atis_pkg::ACT_WRITE, 4'd0, 3'd4, 32'h0));

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < N_RANDOM) begin
                send_word(random_word());
                burst--;
                sent++;
            end
            pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (sb.due_results.size() != 0) begin
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/atis_pkg.sv
design/atis_in_reg.sv
design/atis_exec.sv
design/atis_out_reg.sv
design/alarm_timer_with_irq_suspend_core.sv
tb/testbench.sv
